>>> rtl/impc_pkg.sv
package impc_pkg;

  localparam int unsigned SumW   = 58;
  localparam int unsigned CountW = 27;
  localparam int unsigned CompW  = 16;

  // 10*log10(2) in Q16
  localparam logic [17:0] TenLog2Q16 = 18'd197283;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgPeak   = 2'd2;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrSetup  = 2'd1;
  localparam logic [1:0] ErrCount  = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_SQRT  = 10'b0000001000,
    S_PMUL  = 10'b0000010000,
    S_XMUL  = 10'b0000100000,
    S_LOGA  = 10'b0001000000,
    S_LOGB  = 10'b0010000000,
    S_SCALE = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    L_IDLE = 2'b01,
    L_NORM = 2'b10
  } log_phase_e;

endpackage

>>> rtl/impc_log2.sv
module impc_log2 import impc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [21:0] result_o
);

  log_phase_e  phase_q;
  logic        squaring_q;
  logic        done_q;
  logic [63:0] x_q;
  logic [5:0]  n_q;
  logic [31:0] y_q;
  logic [15:0] frac_q;
  logic [3:0]  step_q;
  logic [63:0] prod;
  logic [32:0] t;

  assign prod = 64'(y_q) * 64'(y_q);
  assign t    = prod[63:31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= L_IDLE;
      squaring_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= !start_i && (phase_q == L_NORM) && squaring_q && (step_q == 4'd0);
      if (start_i) begin
        phase_q    <= L_NORM;
        squaring_q <= 1'b0;
      end else if (phase_q == L_NORM) begin
        if (!squaring_q) begin
          if (x_q[63]) begin
            squaring_q <= 1'b1;
          end
        end else if (step_q == 4'd0) begin
          phase_q    <= L_IDLE;
          squaring_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: normalize one bit a cycle, then square once per fraction bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      n_q    <= 6'd63;
      step_q <= 4'd15;
    end else if (phase_q == L_NORM) begin
      if (!squaring_q) begin
        if (x_q[63]) begin
          y_q <= x_q[63:32];
        end else begin
          x_q <= {x_q[62:0], 1'b0};
          n_q <= n_q - 6'd1;
        end
      end else begin
        if (t[32]) begin
          y_q <= t[32:1];
        end else begin
          y_q <= t[31:0];
        end
        frac_q <= {frac_q[14:0], t[32]};
        step_q <= step_q - 4'd1;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = {n_q, frac_q};

endmodule

>>> rtl/image_mse_psnr_compare_top.sv
// Channel  | Direction | Content
// s_axis   | in        | tdata: candidate_component, reference_component; tlast: last_component
// m_axis   | out       | tdata: error_code, compared_count, max_abs_error, rms_error,
//          |           |        psnr_db, psnr_infinite
// cfg      | in        | index 0 image_width, 1 image_height, 2 peak_signal
//
// A component pair is taken every cycle while idle; each transfer folds into the
// running sum, maximum and count. A last transfer starts the finish sequencer:
// a restoring divide, a square root, two log2 passes (one-bit normalize, then
// 16 squarings each) and the dB scaling. The input holds off until the result
// is loaded into the output register; a stalled output holds the sequencer in
// its final step.
// Reset clears the accumulators, the control state and loads the register defaults.
module image_mse_psnr_compare_top import impc_pkg::*; #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] candidate_component, [31:16] reference_component
  input  logic        s_axis_tlast,   // last_component
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [1:0] error_code, [28:2] compared_count,
                                      // [44:29] max_abs_error, [60:45] rms_error,
                                      // [76:61] psnr_db, [77] psnr_infinite, rest zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  state_e state_q;

  logic [12:0]       width_q, height_q;
  logic [15:0]       peak_q;
  logic [SumW-1:0]   sum_q;
  logic [CompW-1:0]  max_q;
  logic [CountW-1:0] count_q;

  // Result registers
  logic        m_valid_q;
  logic [1:0]  err_q;
  logic [15:0] rms_q;
  logic [15:0] psnr_q;
  logic        inf_q;

  // Sequencer datapath
  logic [5:0]        cnt_q;
  logic [SumW-1:0]   quo_q;
  logic [27:0]       rem_q;
  logic [28:0]       root_q;
  logic [31:0]       srem_q;
  logic [31:0]       pp_q;
  logic [21:0]       la_q;

  // Accumulate path
  logic              accept;
  logic [15:0]       cand, refc, diff;
  logic [31:0]       sq;
  logic [SumW:0]     sum_n;

  assign cand   = s_axis_tdata[15:0];
  assign refc   = s_axis_tdata[31:16];
  assign diff   = (cand >= refc) ? (cand - refc) : (refc - cand);
  assign sq     = 32'(diff) * 32'(diff);
  assign sum_n  = {1'b0, sum_q} + (SumW+1)'(sq);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Load the output register from the final step once it is free
  logic        out_load;
  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  // Setup check
  logic        bad_setup;
  logic [27:0] expected;
  assign bad_setup = (width_q == 13'd0) || (height_q == 13'd0) || (peak_q == 16'd0) ||
                     ({1'b0, width_q} > 14'(MAX_DIM)) || ({1'b0, height_q} > 14'(MAX_DIM));
  assign expected  = {2'b00, 26'(width_q) * 26'(height_q)} << 2;

  // Divide and root steps
  logic [27:0] rem_sh;
  logic [31:0] r2, trial;
  assign rem_sh = {rem_q[26:0], quo_q[SumW-1]};
  assign r2     = {srem_q[29:0], quo_q[SumW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // Log unit
  logic        log_start, log_done;
  logic [63:0] log_x;
  logic [21:0] log_r;
  assign log_start = (state_q == S_XMUL) || ((state_q == S_LOGA) && log_done);
  assign log_x     = (state_q == S_XMUL) ? (64'(pp_q) * 64'(count_q)) : 64'(sum_q);

  impc_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .x_i      (log_x),
    .done_o   (log_done),
    .result_o (log_r)
  );

  // Scale: round the dB product to Q8.8, half away from zero, then saturate
  logic        neg;
  logic [21:0] mag;
  logic [40:0] sprod;
  logic [16:0] q;
  logic [15:0] psnr_n;
  assign neg   = log_r > la_q;
  assign mag   = neg ? (log_r - la_q) : (la_q - log_r);
  assign sprod = 41'(40'(mag) * 40'(TenLog2Q16)) + 41'(1) * 41'h800000;
  assign q     = sprod[40:24];
  always_comb begin
    if (neg) begin
      psnr_n = (q >= 17'd32768) ? 16'h8000 : 16'(17'd0 - q);
    end else begin
      psnr_n = (q > 17'd32767) ? 16'h7FFF : q[15:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      peak_q   <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgWidth:  width_q  <= cfg_data_i[12:0];
        CfgHeight: height_q <= cfg_data_i[12:0];
        CfgPeak:   peak_q   <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Sequencer and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sum_q     <= '0;
      max_q     <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            sum_q <= sum_n[SumW] ? {SumW{1'b1}} : sum_n[SumW-1:0];
            if (diff > max_q) begin
              max_q <= diff;
            end
            if (count_q != {CountW{1'b1}}) begin
              count_q <= count_q + 1'b1;
            end
            if (s_axis_tlast) begin
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (bad_setup || ({1'b0, count_q} != expected) || (count_q == {CountW{1'b1}})
              || (sum_q == '0)) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'd0) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt_q == 6'd0) begin
            state_q <= S_PMUL;
          end
        end
        S_PMUL:  state_q <= S_XMUL;
        S_XMUL:  state_q <= S_LOGA;
        S_LOGA: begin
          if (log_done) begin
            state_q <= S_LOGB;
          end
        end
        S_LOGB: begin
          if (log_done) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: state_q <= S_DONE;
        S_DONE: begin
          // Load the result once the output register is free, then clear
          if (out_load) begin
            sum_q     <= '0;
            max_q     <= '0;
            count_q   <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Finish datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CHECK: begin
        rms_q  <= '0;
        quo_q  <= sum_q;
        rem_q  <= '0;
        cnt_q  <= 6'd57;
        if (bad_setup) begin
          err_q  <= ErrSetup;
          psnr_q <= '0;
          inf_q  <= 1'b0;
        end else if (({1'b0, count_q} != expected) || (count_q == {CountW{1'b1}})) begin
          err_q  <= ErrCount;
          psnr_q <= '0;
          inf_q  <= 1'b0;
        end else begin
          err_q  <= ErrNone;
          psnr_q <= (sum_q == '0) ? 16'h7FFF : 16'h0000;
          inf_q  <= (sum_q == '0);
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, count_q}) begin
          rem_q <= rem_sh - {1'b0, count_q};
          quo_q <= {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[SumW-2:0], 1'b0};
        end
        if (cnt_q == 6'd0) begin
          cnt_q  <= 6'd28;
          root_q <= '0;
          srem_q <= '0;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
      S_SQRT: begin
        if (r2 >= trial) begin
          srem_q <= r2 - trial;
          root_q <= {root_q[27:0], 1'b1};
        end else begin
          srem_q <= r2;
          root_q <= {root_q[27:0], 1'b0};
        end
        quo_q <= quo_q << 2;
        cnt_q <= cnt_q - 6'd1;
      end
      S_PMUL: begin
        rms_q <= (root_q > 29'h0FFFF) ? 16'hFFFF : root_q[15:0];
        pp_q  <= 32'(peak_q) * 32'(peak_q);
      end
      S_LOGA: begin
        if (log_done) begin
          la_q <= log_r;
        end
      end
      S_LOGB: begin
        if (log_done) begin
          psnr_q <= psnr_n;
        end
      end
      default: ;
    endcase
  end

  // Output register
  logic [CountW-1:0] out_count;
  logic [15:0]       out_max;
  logic [26:0]       cnt_hold_q;
  logic [15:0]       max_hold_q;
  logic [1:0]        err_hold_q;
  logic [15:0]       rms_hold_q;
  logic [15:0]       psnr_hold_q;
  logic              inf_hold_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cnt_hold_q  <= (err_q == ErrNone) ? count_q : '0;
      max_hold_q  <= (err_q == ErrNone) ? max_q : '0;
      err_hold_q  <= err_q;
      rms_hold_q  <= rms_q;
      psnr_hold_q <= psnr_q;
      inf_hold_q  <= inf_q;
    end
  end

  assign out_count     = cnt_hold_q;
  assign out_max       = max_hold_q;
  assign m_axis_tdata  = {2'b00, inf_hold_q, psnr_hold_q, rms_hold_q, out_max, out_count,
                          err_hold_q};
  assign m_axis_tvalid = m_valid_q;

endmodule

>>> tb/image_mse_psnr_compare_top_test.sv
`timescale 1ns / 1ps

module image_mse_psnr_compare_top_test;
  import impc_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [15:0] cand;
    logic [15:0] refc;
    logic        last;
  } pair_t;

  // Highest field first, so the layout matches the result tdata
  typedef struct packed {
    logic        inf;
    logic [15:0] psnr;
    logic [15:0] rms;
    logic [15:0] max_err;
    logic [26:0] count;
    logic [1:0]  err;
  } metric_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [15:0] cfg_data_i;

  image_mse_psnr_compare_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_data_i(cfg_data_i)
  );

  // Predictor state: configuration and accumulators
  logic [12:0] img_w, img_h;
  logic [15:0] peak;
  logic [57:0] sse_acc;
  logic [15:0] max_acc;
  logic [26:0] pairs_acc;

  pair_t   pending_pairs[$];
  metric_t expected_metrics[$];
  int      mismatches;
  int      send_idle_pct, recv_idle_pct;
  bit      hold_recv;
  int      hold_cycles;
  int      quiet_cycles;

  // log2 in unsigned Q.16, truncated; fraction by repeated squaring
  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int n;
    logic [63:0] y, r;
    logic [127:0] prod;
    n = 63;
    while (n > 0 && !x[n]) n--;
    y = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
    r = 64'(n) << 16;
    for (int i = 15; i >= 0; i--) begin
      prod = 128'(y) * 128'(y);
      y = 64'(prod >> 31);
      if (y >= (64'd1 << 32)) begin
        y = y >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Fold one accepted pair; queue the image metrics on a last pair
  task automatic fold_pair(pair_t p);
    logic [63:0] d, sq, mse, rms, la, lb, mag, q, expct, ps;
    metric_t m;
    bit neg;
    d = (p.cand >= p.refc) ? 64'(p.cand - p.refc) : 64'(p.refc - p.cand);
    sq = d * d;
    if (64'(sse_acc) > 64'h3FF_FFFF_FFFF_FFFF - sq) sse_acc = '1;
    else sse_acc = sse_acc + 58'(sq);
    if (d > 64'(max_acc)) max_acc = d[15:0];
    if (pairs_acc != '1) pairs_acc++;
    if (!p.last) return;
    m = '0;
    expct = 64'(img_w) * 64'(img_h) * 4;
    if (img_w == 0 || img_h == 0 || peak == 0 || img_w > 4096 || img_h > 4096) begin
      m.err = ErrSetup;
    end else if (64'(pairs_acc) != expct || pairs_acc == '1) begin
      m.err = ErrCount;
    end else begin
      m.err = ErrNone;
      m.count = pairs_acc;
      m.max_err = max_acc;
      if (sse_acc == 0) begin
        m.psnr = 16'd32767;
        m.inf = 1'b1;
      end else begin
        mse = 64'(sse_acc) / 64'(pairs_acc);
        rms = int_sqrt(mse);
        la = log2_fix(64'(peak) * 64'(peak) * 64'(pairs_acc));
        lb = log2_fix(64'(sse_acc));
        neg = lb > la;
        mag = neg ? lb - la : la - lb;
        q = (mag * 64'd197283 + (64'd1 << 23)) >> 24;
        if (rms > 64'hFFFF) rms = 64'hFFFF;
        if (neg) ps = (q >= 32768) ? 64'h8000 : ((64'd0 - q) & 64'hFFFF);
        else ps = (q > 32767) ? 64'd32767 : q;
        m.rms = rms[15:0];
        m.psnr = ps[15:0];
      end
    end
    expected_metrics = {expected_metrics, m};
    sse_acc = '0;
    max_acc = '0;
    pairs_acc = '0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Driver: offer pending pairs, idle at random
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      fold_pair(pending_pairs.pop_front());
    end
    if ((!s_axis_tvalid || s_axis_tready) && rst_ni) begin
      if (pending_pairs.size() > 0 && ($urandom_range(99) >= send_idle_pct
          || (s_axis_tvalid && s_axis_tready && pending_pairs.size() == 0))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_pairs[0].refc, pending_pairs[0].cand};
        s_axis_tlast  <= pending_pairs[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    metric_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[77:0];
      if (expected_metrics.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.err), 64'd0);
      end else begin
        want = expected_metrics.pop_front();
        if (got.err !== want.err)
          report_mismatch("error_code", 64'(got.err), 64'(want.err));
        if (got.count !== want.count)
          report_mismatch("count", 64'(got.count), 64'(want.count));
        if (got.max_err !== want.max_err)
          report_mismatch("max_abs", 64'(got.max_err), 64'(want.max_err));
        if (got.rms !== want.rms)
          report_mismatch("rms", 64'(got.rms), 64'(want.rms));
        if (got.psnr !== want.psnr)
          report_mismatch("psnr", 64'(got.psnr), 64'(want.psnr));
        if (got.inf !== want.inf)
          report_mismatch("psnr_inf", 64'(got.inf), 64'(want.inf));
      end
    end
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    m_axis_tready <= rst_ni && !hold_recv && hold_cycles == 0
                     && $urandom_range(99) >= recv_idle_pct;
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgWidth) img_w = val[12:0];
    else if (idx == CfgHeight) img_h = val[12:0];
    else if (idx == CfgPeak) peak = val;
  endtask

  // Wait for the block to drain, including the finish sequencer
  task automatic drain();
    while (pending_pairs.size() > 0 || s_axis_tvalid || expected_metrics.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic push_pair(logic [15:0] c, logic [15:0] r, logic last);
    pair_t p;
    p.cand = c;
    p.refc = r;
    p.last = last;
    pending_pairs = {pending_pairs, p};
  endtask

  // One image of n pairs; mode picks the content style
  task automatic push_image(int n, int mode);
    logic [15:0] c, r;
    for (int i = 0; i < n; i++) begin
      c = 16'($urandom);
      case (mode)
        0: r = c;
        1: r = c + 16'($urandom_range(64)) - 16'd32;
        default: r = 16'($urandom);
      endcase
      push_pair(c, r, i == n - 1);
    end
  endtask

  task automatic set_extent(logic [15:0] w, logic [15:0] h, logic [15:0] pk);
    drain();
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
    write_reg(CfgPeak, pk);
  endtask

  // Random images, mostly matching the configured extent
  task automatic random_phase(int images);
    int n, nominal;
    nominal = int'(img_w) * int'(img_h) * 4;
    for (int k = 0; k < images; k++) begin
      if ($urandom_range(9) < 8 && nominal > 0 && nominal <= 64) n = nominal;
      else n = $urandom_range(1, 12);
      push_image(n, $urandom_range(2));
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CfgWidth;
    cfg_data_i    = '0;
    mismatches    = 0;
    hold_recv     = 1'b0;
    hold_cycles   = 0;
    quiet_cycles  = 0;
    send_idle_pct = 18;
    recv_idle_pct = 59;
    img_w = '0;
    img_h = '0;
    peak  = 16'd4096;
    sse_acc = '0;
    max_acc = '0;
    pairs_acc = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset extent is zero: setup error
    push_pair(16'h0000, 16'hFFFF, 1'b1);
    set_extent(16'd1, 16'd1, 16'hFFFF);
    // Extremes of the components, with and without error
    push_pair(16'hFFFF, 16'h0000, 1'b0);
    push_pair(16'h0000, 16'hFFFF, 1'b0);
    push_pair(16'hAAAA, 16'h5555, 1'b0);
    push_pair(16'h5555, 16'hAAAA, 1'b1);
    push_image(4, 0);                      // zero error: infinite psnr
    push_image(3, 2);                      // count mismatch
    push_image(5, 1);
    set_extent(16'd1, 16'd1, 16'd0);       // zero peak
    push_image(4, 2);
    set_extent(16'd4097, 16'd1, 16'd1);    // oversize width
    push_image(2, 1);
    set_extent(16'd1, 16'd8191, 16'd1);    // oversize height, tiny peak
    push_image(2, 1);
    set_extent(16'd1, 16'd1, 16'd1);       // very negative psnr
    push_pair(16'hFFFF, 16'h0000, 1'b0);
    push_pair(16'hFFFF, 16'h0000, 1'b0);
    push_pair(16'hFFFF, 16'h0000, 1'b0);
    push_pair(16'h0000, 16'hFFFF, 1'b1);
    set_extent(16'd4096, 16'd4096, 16'd4096); // max extent, short stream mismatches
    push_image(3, 1);

    set_extent(16'd2, 16'd2, 16'd4096);
    random_phase(30);
    // Long receiver hold-off while pairs keep coming
    drain();
    hold_cycles = 1500;
    push_image(16, 2);
    push_image(16, 1);
    set_extent(16'd1, 16'd2, 16'($urandom_range(1, 65535)));
    random_phase(30);
    send_idle_pct = 59;
    recv_idle_pct = 18;
    set_extent(16'd2, 16'd1, 16'hFFFF);
    random_phase(30);
    set_extent(16'd1, 16'd1, 16'($urandom));
    random_phase(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_extent(16'd2, 16'd2, 16'd1);
    random_phase(30);
    set_extent(16'd1, 16'd1, 16'd4096);
    random_phase(40);
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/impc_pkg.sv
rtl/impc_log2.sv
rtl/image_mse_psnr_compare_top.sv
tb/image_mse_psnr_compare_top_test.sv
